/* sv/pdvm_pkg.sv */
`default_nettype none

package pdvm_pkg;

  // Field and datapath widths
  localparam int TGT_W    = 19;
  localparam int MEAS_W   = 18;
  localparam int OPEN_W   = 18;
  localparam int DUTY_W   = 17;
  localparam int ERR_W    = 20;  // clamped target minus measured
  localparam int A_W      = 21;  // error offset from the segment start
  localparam int AMAG_W   = 20;
  localparam int DMAG_W   = 17;
  localparam int DENX_W   = 20;  // signed span length before the empty check
  localparam int DEN_W    = 19;  // span length when not empty
  localparam int Y_W      = 18;  // opening limits, sign extended
  localparam int Q_W      = 18;  // quotient bits, top bit flags saturation
  localparam int PROD_W   = 37;
  localparam int SUM_W    = 20;
  localparam int BIT_W    = 5;
  localparam int CNT_W    = 5;
  localparam int PIPE_DEPTH = 3 + Q_W + 3;

  localparam logic signed [TGT_W-1:0]  TARGET_LOW  = -19'sd100000;
  localparam logic signed [TGT_W-1:0]  TARGET_HIGH = 19'sd180000;
  localparam logic signed [OPEN_W-1:0] Q16_ONE     = 18'sd65536;
  localparam logic [Q_W-1:0]           Q_SAT       = 18'h20000;

  // APB register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_DEAD_ZONE,
    REG_POS_SPAN,
    REG_NEG_SPAN,
    REG_OPEN_MIN_NEG,
    REG_OPEN_MAX_NEG,
    REG_OPEN_MIN_POS,
    REG_OPEN_MAX_POS
  } reg_idx_e;

  localparam logic [17:0]        RST_DEAD_ZONE    = 18'd2000;
  localparam logic [17:0]        RST_POS_SPAN     = 18'd30000;
  localparam logic signed [18:0] RST_NEG_SPAN     = -19'sd30000;
  localparam logic signed [16:0] RST_OPEN_MIN_NEG = -17'sd65536;
  localparam logic signed [16:0] RST_OPEN_MAX_NEG = -17'sd62259;
  localparam logic [16:0]        RST_OPEN_MIN_POS = 17'd62259;
  localparam logic [16:0]        RST_OPEN_MAX_POS = 17'd65536;

  typedef struct packed {
    logic [17:0]        dead_zone;
    logic [17:0]        pos_span;
    logic signed [18:0] neg_span;
    logic signed [16:0] open_min_neg;
    logic signed [16:0] open_max_neg;
    logic [16:0]        open_min_pos;
    logic [16:0]        open_max_pos;
  } cfg_t;

  // Word handed through the divider stages
  typedef struct packed {
    logic [PROD_W-1:0]     rem;
    logic [DEN_W-1:0]      den;
    logic [Q_W-1:0]        quo;
    logic                  neg;
    logic                  empty;
    logic signed [Y_W-1:0] y0;
    logic signed [Y_W-1:0] y1;
    logic signed [Y_W-1:0] fb;
  } div_word_t;

endpackage

`default_nettype wire

/* sv/pdvm_if.sv */
`default_nettype none

interface pdvm_in_if;
  logic              valid;
  logic              ready;
  logic signed [18:0] target_pressure;
  logic [17:0]       measured_pressure;

  modport source (output valid, target_pressure, measured_pressure, input ready);
  modport sink   (input valid, target_pressure, measured_pressure, output ready);
endinterface

interface pdvm_out_if;
  logic              valid;
  logic              ready;
  logic signed [17:0] opening;
  logic [16:0]       inflate_duty;
  logic [16:0]       exhaust_duty;

  modport source (output valid, opening, inflate_duty, exhaust_duty, input ready);
  modport sink   (input valid, opening, inflate_duty, exhaust_duty, output ready);
endinterface

`default_nettype wire

/* sv/pdvm_cfg.sv */
`default_nettype none

module pdvm_cfg import pdvm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone    <= RST_DEAD_ZONE;
      cfg_q.pos_span     <= RST_POS_SPAN;
      cfg_q.neg_span     <= RST_NEG_SPAN;
      cfg_q.open_min_neg <= RST_OPEN_MIN_NEG;
      cfg_q.open_max_neg <= RST_OPEN_MAX_NEG;
      cfg_q.open_min_pos <= RST_OPEN_MIN_POS;
      cfg_q.open_max_pos <= RST_OPEN_MAX_POS;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEAD_ZONE:    cfg_q.dead_zone    <= pwdata[17:0];
        REG_POS_SPAN:     cfg_q.pos_span     <= pwdata[17:0];
        REG_NEG_SPAN:     cfg_q.neg_span     <= $signed(pwdata[18:0]);
        REG_OPEN_MIN_NEG: cfg_q.open_min_neg <= $signed(pwdata[16:0]);
        REG_OPEN_MAX_NEG: cfg_q.open_max_neg <= $signed(pwdata[16:0]);
        REG_OPEN_MIN_POS: cfg_q.open_min_pos <= pwdata[16:0];
        REG_OPEN_MAX_POS: cfg_q.open_max_pos <= pwdata[16:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEAD_ZONE:    prdata = {14'd0, cfg_q.dead_zone};
      REG_POS_SPAN:     prdata = {14'd0, cfg_q.pos_span};
      REG_NEG_SPAN:     prdata = {13'd0, cfg_q.neg_span};
      REG_OPEN_MIN_NEG: prdata = {15'd0, cfg_q.open_min_neg};
      REG_OPEN_MAX_NEG: prdata = {15'd0, cfg_q.open_max_neg};
      REG_OPEN_MIN_POS: prdata = {15'd0, cfg_q.open_min_pos};
      REG_OPEN_MAX_POS: prdata = {15'd0, cfg_q.open_max_pos};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/pdvm_front.sv */
`default_nettype none

// Three stages: error, segment operands, magnitude product.
module pdvm_front import pdvm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  pdvm_in_if.sink   sample_i,
  output logic      valid_o,
  input  logic      ready_i,
  output div_word_t word_o
);

  // stage 1
  logic                    s1_vld_q, s1_rdy;
  logic signed [ERR_W-1:0] s1_err_q, s1_err_d;
  logic signed [TGT_W-1:0] tgt_c;

  // stage 2
  logic                     s2_vld_q, s2_rdy;
  logic signed [A_W-1:0]    s2_a_q, s2_a_d;
  logic signed [Y_W-1:0]    s2_d_q, s2_d_d;
  logic [DEN_W-1:0]         s2_den_q, s2_den_d;
  logic                     s2_empty_q, s2_empty_d;
  logic signed [Y_W-1:0]    s2_y0_q, s2_y0_d, s2_y1_q, s2_y1_d, s2_fb_q, s2_fb_d;
  logic signed [A_W-1:0]    err_x, dz_x, ns_x;
  logic signed [DENX_W-1:0] den_x;

  // stage 3
  logic              s3_vld_q, s3_rdy;
  div_word_t         s3_q, s3_d;
  logic [AMAG_W-1:0] a_mag;
  logic [DMAG_W-1:0] d_mag;

  assign s1_rdy         = !s1_vld_q || s2_rdy;
  assign s2_rdy         = !s2_vld_q || s3_rdy;
  assign s3_rdy         = !s3_vld_q || ready_i;
  assign sample_i.ready = s1_rdy;
  assign valid_o        = s3_vld_q;
  assign word_o         = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_q <= sample_i.valid;
      if (s2_rdy) s2_vld_q <= s1_vld_q;
      if (s3_rdy) s3_vld_q <= s2_vld_q;
    end
  end

  // Stage 1: clamp target, form error
  always_comb begin
    if (sample_i.target_pressure < TARGET_LOW)       tgt_c = TARGET_LOW;
    else if (sample_i.target_pressure > TARGET_HIGH) tgt_c = TARGET_HIGH;
    else                                             tgt_c = sample_i.target_pressure;
    s1_err_d = ERR_W'(tgt_c) - $signed({2'b00, sample_i.measured_pressure});
  end

  // Stage 2: pick the segment and its linear-map operands
  always_comb begin
    err_x = A_W'(s1_err_q);
    dz_x  = $signed({3'b000, cfg_i.dead_zone});
    ns_x  = A_W'(cfg_i.neg_span);
    s2_a_d     = '0;
    s2_d_d     = '0;
    s2_y0_d    = '0;
    s2_y1_d    = '0;
    s2_fb_d    = '0;
    den_x      = '0;
    s2_empty_d = 1'b1;  // dead zone: all limits zero gives zero
    if (err_x > dz_x) begin
      s2_a_d  = err_x - dz_x;
      s2_y0_d = $signed({1'b0, cfg_i.open_min_pos});
      s2_y1_d = $signed({1'b0, cfg_i.open_max_pos});
      s2_d_d  = s2_y1_d - s2_y0_d;
      s2_fb_d = s2_y1_d;
      den_x   = $signed({2'b00, cfg_i.pos_span}) - $signed({2'b00, cfg_i.dead_zone});
      s2_empty_d = (den_x <= 0);
    end else if (err_x < -dz_x) begin
      s2_a_d  = err_x - ns_x;
      s2_y0_d = Y_W'(cfg_i.open_min_neg);
      s2_y1_d = Y_W'(cfg_i.open_max_neg);
      s2_d_d  = s2_y1_d - s2_y0_d;
      s2_fb_d = s2_y0_d;
      den_x   = -$signed({2'b00, cfg_i.dead_zone}) - DENX_W'(cfg_i.neg_span);
      s2_empty_d = (den_x <= 0);
    end
    s2_den_d = den_x[DEN_W-1:0];
  end

  // Stage 3: magnitudes and product
  always_comb begin
    a_mag = s2_a_q[A_W-1] ? AMAG_W'(-s2_a_q) : AMAG_W'(s2_a_q);
    d_mag = s2_d_q[Y_W-1] ? DMAG_W'(-s2_d_q) : DMAG_W'(s2_d_q);
    s3_d.rem   = {{(PROD_W-AMAG_W){1'b0}}, a_mag} * {{(PROD_W-DMAG_W){1'b0}}, d_mag};
    s3_d.den   = s2_den_q;
    s3_d.quo   = '0;
    s3_d.neg   = s2_a_q[A_W-1] ^ s2_d_q[Y_W-1];
    s3_d.empty = s2_empty_q;
    s3_d.y0    = s2_y0_q;
    s3_d.y1    = s2_y1_q;
    s3_d.fb    = s2_fb_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && sample_i.valid) s1_err_q <= s1_err_d;
    if (s2_rdy && s1_vld_q) begin
      s2_a_q     <= s2_a_d;
      s2_d_q     <= s2_d_d;
      s2_den_q   <= s2_den_d;
      s2_empty_q <= s2_empty_d;
      s2_y0_q    <= s2_y0_d;
      s2_y1_q    <= s2_y1_d;
      s2_fb_q    <= s2_fb_d;
    end
    if (s3_rdy && s2_vld_q) s3_q <= s3_d;
  end

endmodule

`default_nettype wire

/* sv/pdvm_div_step.sv */
`default_nettype none

// One restoring-division step: quotient bit bit_i.
module pdvm_div_step import pdvm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BIT_W-1:0] bit_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  div_word_t        word_i,
  output logic             valid_o,
  input  logic             ready_i,
  output div_word_t        word_o
);

  logic              vld_q;
  div_word_t         word_q, word_d;
  logic [PROD_W-1:0] den_sh;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign word_o  = word_q;

  always_comb begin
    word_d = word_i;
    den_sh = {{(PROD_W-DEN_W){1'b0}}, word_i.den} << bit_i;
    if (word_i.rem >= den_sh) begin
      word_d.rem = word_i.rem - den_sh;
      word_d.quo = word_i.quo | (Q_W'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) word_q <= word_d;
  end

endmodule

`default_nettype wire

/* sv/pdvm_back.sv */
`default_nettype none

// Three stages: offset from y0, clamp to the segment limits, saturate and split.
module pdvm_back import pdvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  div_word_t   word_i,
  pdvm_out_if.source  result_o
);

  logic                    b1_vld_q, b1_rdy;
  logic signed [SUM_W-1:0] b1_v_q, b1_v_d;
  logic signed [Y_W-1:0]   b1_y0_q, b1_y1_q;
  logic [Q_W-1:0]          qmag;
  logic signed [SUM_W-1:0] qs;

  logic                    b2_vld_q, b2_rdy;
  logic signed [Y_W-1:0]   b2_v_q, b2_v_d, lo, hi;

  logic                    o_vld_q, o_rdy;
  logic signed [OPEN_W-1:0] op_d, op_q, op_neg;
  logic [DUTY_W-1:0]       inf_q, inf_d, exh_q, exh_d;

  assign ready_o = b1_rdy;
  assign b1_rdy  = !b1_vld_q || b2_rdy;
  assign b2_rdy  = !b2_vld_q || o_rdy;
  assign o_rdy   = !o_vld_q || result_o.ready;

  assign result_o.valid        = o_vld_q;
  assign result_o.opening      = op_q;
  assign result_o.inflate_duty = inf_q;
  assign result_o.exhaust_duty = exh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (b1_rdy) b1_vld_q <= valid_i;
      if (b2_rdy) b2_vld_q <= b1_vld_q;
      if (o_rdy)  o_vld_q  <= b2_vld_q;
    end
  end

  // top quotient bit set: quotient beyond any limit span, pin it
  always_comb begin
    qmag = word_i.quo[Q_W-1] ? Q_SAT : word_i.quo;
    qs   = $signed({{(SUM_W-Q_W){1'b0}}, qmag});
    if (word_i.empty) b1_v_d = SUM_W'(word_i.fb);
    else if (word_i.neg) b1_v_d = SUM_W'(word_i.y0) - qs;
    else                 b1_v_d = SUM_W'(word_i.y0) + qs;
  end

  always_comb begin
    if (b1_y0_q <= b1_y1_q) begin
      lo = b1_y0_q;
      hi = b1_y1_q;
    end else begin
      lo = b1_y1_q;
      hi = b1_y0_q;
    end
    if (b1_v_q < SUM_W'(lo))      b2_v_d = lo;
    else if (b1_v_q > SUM_W'(hi)) b2_v_d = hi;
    else                          b2_v_d = Y_W'(b1_v_q);
  end

  always_comb begin
    if (b2_v_q > Q16_ONE)       op_d = Q16_ONE;
    else if (b2_v_q < -Q16_ONE) op_d = -Q16_ONE;
    else                        op_d = b2_v_q;
    op_neg = -op_d;
    if (op_d > 0) begin
      inf_d = op_d[DUTY_W-1:0];
      exh_d = '0;
    end else begin
      inf_d = '0;
      exh_d = op_neg[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_rdy && valid_i) begin
      b1_v_q  <= b1_v_d;
      b1_y0_q <= word_i.y0;
      b1_y1_q <= word_i.y1;
    end
    if (b2_rdy && b1_vld_q) b2_v_q <= b2_v_d;
    if (o_rdy && b2_vld_q) begin
      op_q  <= op_d;
      inf_q <= inf_d;
      exh_q <= exh_d;
    end
  end

endmodule

`default_nettype wire

/* sv/pressure_deadband_valve_mapper.sv */
// A word accepted on sample_i is offered on result_o after passing 24 register stages
//   (3 front, 18 divider steps, 3 back).
// Throughput: one word per cycle while result_o.ready stays high; each stage holds its word while the next one is full.
// The divider is one restoring step per stage, so its 18 quotient bits set the depth.
// Reset (rst_ni low, asynchronous): all stages empty, configuration registers back to their defaults.
`default_nettype none

module pressure_deadband_valve_mapper import pdvm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pdvm_in_if.sink            sample_i,
  pdvm_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;

  // Divider chain: link 0 comes from the front end, link Q_W feeds the back end
  logic      dv  [0:Q_W];
  logic      dr  [0:Q_W];
  div_word_t dw  [0:Q_W];

  pdvm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Clamp, error, segment choice and |offset| * |limit span|
  pdvm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (sample_i),
    .valid_o  (dv[0]),
    .ready_i  (dr[0]),
    .word_o   (dw[0])
  );

  // Quotient bits MSB first; the top bit only flags a quotient past the limit span
  for (genvar g = 0; g < Q_W; g++) begin : g_div
    pdvm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (BIT_W'(Q_W - 1 - g)),
      .valid_i (dv[g]),
      .ready_o (dr[g]),
      .word_i  (dw[g]),
      .valid_o (dv[g+1]),
      .ready_i (dr[g+1]),
      .word_o  (dw[g+1])
    );
  end

  // Offset, clamp to the segment, saturate to one and split into duties
  pdvm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv[Q_W]),
    .ready_o  (dr[Q_W]),
    .word_i   (dw[Q_W]),
    .result_o (result_o)
  );

  // Words in flight, for the checks below
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_q;

  assign in_acc  = sample_i.valid && sample_i.ready;
  assign out_acc = result_o.valid && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - CNT_W'(1);
    end
  end

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> inflight_q != '0)
    else $error("result offered with no word in flight");

  a_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.opening <= Q16_ONE && result_o.opening >= -Q16_ONE))
    else $error("opening beyond full scale");

  a_one_valve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.inflate_duty == '0 || result_o.exhaust_duty == '0))
    else $error("both valves driven");

endmodule

`default_nettype wire
